// ===== rtl/mf3_pkg.sv =====
// Shared types and constants for the 3x3 median filter.
`timescale 1ns / 1ps
package mf3_pkg;
  localparam int unsigned PixW = 32;
  // deepest row the line stores hold; column fields are sized for it
  localparam int unsigned MaxWidth = 2048;
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegFour   = 2'd2;

  typedef logic [PixW-1:0] pix_t;

  typedef struct packed {
    logic       interior;
    logic       last;
    logic [11:0] row;
    logic [10:0] col;
  } res_info_t;

  function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? b : a;
  endfunction

  // Classic 19-exchange median-of-nine network.
  function automatic logic [7:0] med9(input logic [71:0] v);
    logic [7:0] p [9];
    logic [7:0] t;
    for (int i = 0; i < 9; i++) p[i] = v[i*8 +: 8];
    t = min8(p[1], p[2]); p[2] = max8(p[1], p[2]); p[1] = t;
    t = min8(p[4], p[5]); p[5] = max8(p[4], p[5]); p[4] = t;
    t = min8(p[7], p[8]); p[8] = max8(p[7], p[8]); p[7] = t;
    t = min8(p[0], p[1]); p[1] = max8(p[0], p[1]); p[0] = t;
    t = min8(p[3], p[4]); p[4] = max8(p[3], p[4]); p[3] = t;
    t = min8(p[6], p[7]); p[7] = max8(p[6], p[7]); p[6] = t;
    t = min8(p[1], p[2]); p[2] = max8(p[1], p[2]); p[1] = t;
    t = min8(p[4], p[5]); p[5] = max8(p[4], p[5]); p[4] = t;
    t = min8(p[7], p[8]); p[8] = max8(p[7], p[8]); p[7] = t;
    p[3] = max8(p[0], p[3]);
    p[5] = min8(p[5], p[8]);
    t = min8(p[4], p[7]); p[7] = max8(p[4], p[7]); p[4] = t;
    p[6] = max8(p[3], p[6]);
    p[4] = max8(p[1], p[4]);
    p[2] = min8(p[2], p[5]);
    p[4] = min8(p[4], p[7]);
    t = min8(p[4], p[2]); p[2] = max8(p[4], p[2]); p[4] = t;
    p[4] = max8(p[6], p[4]);
    p[4] = min8(p[4], p[2]);
    return p[4];
  endfunction
endpackage

// ===== rtl/median_filter_3x3.sv =====
// 3x3 median filter over a raster-order RGBA pixel stream.
// One pixel per clock sustained: each accepted item reads both line stores in
// the cycle it enters (one synchronous read port per store), the window shifts
// and the sorting network is registered in the next two stages; throughput is
// one item per cycle, paused only while the output register is full and not
// taken. Results lag the input by one row plus one pixel; after a frame,
// width+1 flush items drain it. Border pixels give zero colour and alpha fields.
`timescale 1ns / 1ps
module median_filter_3x3
  import mf3_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
  input  logic        s_axis_tuser,   // is_flush
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // red, green, blue, alpha, out_row, out_col, pad
  output logic        m_axis_tlast,   // last_of_frame
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned AW = $clog2(MaxWidth);

  logic [11:0] width_q, height_q;
  logic        four_q;
  logic [1:0]  reg_idx;
  assign reg_idx = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd640;
      height_q <= 12'd480;
      four_q   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegWidth:  width_q  <= pwdata[11:0];
        RegHeight: height_q <= pwdata[11:0];
        RegFour:   four_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegWidth:  prdata = {20'd0, width_q};
      RegHeight: prdata = {20'd0, height_q};
      RegFour:   prdata = {31'd0, four_q};
      default:   prdata = '0;
    endcase
  end

  // effective sizes
  logic [12:0] w_eff;
  logic [11:0] h_eff;
  always_comb begin
    w_eff = {1'b0, width_q};
    if (w_eff < 13'd3) w_eff = 13'd3;
    if (w_eff > 13'(MaxWidth)) w_eff = 13'(MaxWidth);
    h_eff = (height_q < 12'd3) ? 12'd3 : height_q;
  end

  // pipeline: s1 = memory read, s2 = window + sort, s3 = output register
  logic s1_v_q, s2_v_q, out_v_q;
  logic adv;
  assign adv = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;
  logic acc;
  assign acc = s_axis_tvalid && adv;

  logic [15:0] in_row_q, res_row_q;
  logic [10:0] in_col_q, res_col_q;
  logic [11:0] in_colw;

  logic [AW-1:0] mcol;
  always_comb begin
    if ({5'd0, in_col_q} < 16'(MaxWidth)) mcol = AW'(in_col_q);
    else mcol = '0;
  end

  pix_t pix;
  assign pix = (in_row_q < {4'd0, h_eff} && !s_axis_tuser) ? s_axis_tdata : '0;

  logic emit;
  assign emit = in_row_q >= 16'd2 || (in_row_q == 16'd1 && in_col_q >= 11'd1);

  logic        interior, last;
  assign interior = res_row_q >= 16'd1 && (res_row_q + 16'd2) <= {4'd0, h_eff} &&
                    res_col_q >= 11'd1 && ({2'b0, res_col_q} + 13'd2) <= w_eff;
  assign last = (res_row_q + 16'd1) >= {4'd0, h_eff} &&
                ({2'b0, res_col_q} + 13'd1) >= w_eff;
  assign in_colw = {1'b0, in_col_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q <= '0; in_col_q <= '0; res_row_q <= '0; res_col_q <= '0;
    end else if (acc) begin
      if (emit && last) begin
        in_row_q <= '0; in_col_q <= '0; res_row_q <= '0; res_col_q <= '0;
      end else begin
        if ({1'b0, in_colw} + 13'd1 >= w_eff) begin
          in_col_q <= '0;
          if (in_row_q != 16'hFFFF) in_row_q <= in_row_q + 16'd1;
        end else in_col_q <= in_col_q + 11'd1;
        if (emit) begin
          if ({2'b0, res_col_q} + 13'd1 >= w_eff) begin
            res_col_q <= '0;
            if (res_row_q != 16'hFFFF) res_row_q <= res_row_q + 16'd1;
          end else res_col_q <= res_col_q + 11'd1;
        end
      end
    end
  end

  // line stores: read old entries, write new; one access per entry per item
  pix_t older_mem [MaxWidth];
  pix_t newer_mem [MaxWidth];
  pix_t top_q, mid_q, pix_q;
  pix_t byp_top_q, byp_mid_q;
  logic byp_q;
  pix_t top_s, mid_s;
  logic s1_fire;
  assign s1_fire = s1_v_q && adv;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      top_q <= older_mem[mcol];
      mid_q <= newer_mem[mcol];
    end
  end

  res_info_t s1_info_q, s2_info_q;
  logic s1_emit_q, s2_emit_q;
  logic [AW-1:0] s1_col_q;

  // the previous item writes its column at the edge this one reads it: bypass
  always_ff @(posedge clk_i) begin
    if (acc) begin
      pix_q <= pix;
      s1_col_q <= mcol;
      s1_info_q <= '{interior: interior, last: last, row: res_row_q[11:0], col: res_col_q};
      s1_emit_q <= emit;
      byp_q <= s1_fire && (s1_col_q == mcol);
      byp_top_q <= mid_s;
      byp_mid_q <= pix_q;
    end
  end

  assign top_s = byp_q ? byp_top_q : top_q;
  assign mid_s = byp_q ? byp_mid_q : mid_q;

  // stage 2: write memories, shift window
  pix_t win_q [9];

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      older_mem[s1_col_q] <= mid_s;
      newer_mem[s1_col_q] <= pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (s1_fire) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= top_s;
      win_q[5] <= mid_s;
      win_q[8] <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_info_q <= s1_info_q;
      s2_emit_q <= s1_emit_q;
    end
  end

  // stage 3: medians into output register
  logic [71:0] cr, cg, cb;
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      cr[i*8 +: 8] = win_q[i][7:0];
      cg[i*8 +: 8] = win_q[i][15:8];
      cb[i*8 +: 8] = win_q[i][23:16];
    end
  end

  logic s2_fire;
  assign s2_fire = s2_v_q && adv;
  logic [7:0] r_q, g_q, b_q, a_q;
  logic [11:0] orow_q;
  logic [10:0] ocol_q;
  logic olast_q;

  always_ff @(posedge clk_i) begin
    if (s2_fire && s2_emit_q) begin
      r_q <= s2_info_q.interior ? med9(cr) : 8'd0;
      g_q <= s2_info_q.interior ? med9(cg) : 8'd0;
      b_q <= s2_info_q.interior ? med9(cb) : 8'd0;
      a_q <= (s2_info_q.interior && four_q) ? win_q[4][31:24] : 8'd0;
      orow_q <= s2_info_q.row;
      ocol_q <= s2_info_q.col;
      olast_q <= s2_info_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= acc;
      s2_v_q <= s1_v_q;
      out_v_q <= s2_v_q && s2_emit_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {1'b0, ocol_q, orow_q, a_q, b_q, g_q, r_q};
  assign m_axis_tlast = olast_q;
endmodule
